@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sliding-window mode-frequency block.
// Expects a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SWM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swm assertion failed");

// The condition must never be true outside reset.
`define SWM_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("swm forbidden condition seen");

`endif

@@ rtl/swm_pkg.sv @@
// Shared constants for the sliding-window mode-frequency block.
// No dependencies; used by the engine and the top level.
package swm_pkg;

  localparam int DEF_ARRAY_DEPTH = 1024;
  localparam int DEF_VALUE_RANGE = 1024;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 10;
  localparam int VALUE_W  = 10;
  localparam int FREQ_W   = 11;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
  // The remaining code is taken and ignored.
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

endpackage

@@ rtl/sliding_window_mode_frequency.sv @@
// Top level of the sliding-window mode-frequency block.
// Uses swm_pkg, swm_ram, swm_engine and assert_macros.svh.

// Answers "how often does the most frequent value occur in [left_end, right_end]"
// over a loaded array, keeping one window whose ends move one element at a time.
// After reset a clearing pass over the VALUE_RANGE + ARRAY_DEPTH + 1 entries
// (2049 at the defaults) zeroes the count memory; no item is taken meanwhile.
// For each element by which a query moves the window ends, the block runs a
// read-modify-write sequence on the single-port count memory (value count,
// then the count-of-counts entries). A bad query answers without moving the
// window. A load into the window also takes the old value out of the counts
// and puts the new one in. A clear removes the elements left in the window one
// at a time. A finished result waits in the output register while the next item
// is taken.
module sliding_window_mode_frequency import swm_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_RANGE = DEF_VALUE_RANGE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]    position,
  input  logic [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]    left_end,
  input  logic [POS_W-1:0]    right_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FREQ_W-1:0]   max_frequency,
  output logic                range_error
);

`include "assert_macros.svh"

  localparam int AW   = $clog2(ARRAY_DEPTH);
  localparam int VW   = $clog2(VALUE_RANGE);
  localparam int CW   = $clog2(ARRAY_DEPTH + 1);
  localparam int CMD  = VALUE_RANGE + ARRAY_DEPTH + 1;
  localparam int CMAW = $clog2(CMD);

  logic            st_we;
  logic [AW-1:0]   st_addr;
  logic [VW-1:0]   st_wdata;
  logic [VW-1:0]   st_rdata;
  logic            cm_we;
  logic [CMAW-1:0] cm_addr;
  logic [CW-1:0]   cm_wdata;
  logic [CW-1:0]   cm_rdata;

  swm_engine #(
    .ARRAY_DEPTH(ARRAY_DEPTH),
    .VALUE_RANGE(VALUE_RANGE)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .position      (position),
    .value         (value),
    .left_end      (left_end),
    .right_end     (right_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .max_frequency (max_frequency),
    .range_error   (range_error),
    .st_we         (st_we),
    .st_addr       (st_addr),
    .st_wdata      (st_wdata),
    .st_rdata      (st_rdata),
    .cm_we         (cm_we),
    .cm_addr       (cm_addr),
    .cm_wdata      (cm_wdata),
    .cm_rdata      (cm_rdata)
  );

  // Loaded values, one entry per array position.
  swm_ram #(
    .DEPTH(ARRAY_DEPTH),
    .WIDTH(VW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // Per-value counts below VALUE_RANGE, count-of-counts table above it.
  swm_ram #(
    .DEPTH(CMD),
    .WIDTH(CW)
  ) u_counts (
    .clk   (clk),
    .we    (cm_we),
    .addr  (cm_addr),
    .wdata (cm_wdata),
    .rdata (cm_rdata)
  );

  `SWM_NEVER(a_err_zero, out_valid && range_error && (max_frequency != '0))
  `SWM_ASSERT(a_accept_busy, (in_valid && in_ready && (action != ACT_NONE)) |=> !in_ready)
  `SWM_ASSERT(a_result_busy, $rose(out_valid) |-> !$past(in_ready))

endmodule

@@ rtl/swm_ram.sv @@
// Single-port synchronous RAM with a registered read.
// Holds the value store and the count memory of the block; no dependencies.
module swm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/swm_engine.sv @@
// Sequencer of the sliding-window mode-frequency block: handshakes, window
// moves and the read-modify-write steps on the two memories. Uses swm_pkg.
module swm_engine import swm_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  localparam int AW   = $clog2(ARRAY_DEPTH),
  localparam int VW   = $clog2(VALUE_RANGE),
  localparam int CW   = $clog2(ARRAY_DEPTH + 1),
  localparam int CMD  = VALUE_RANGE + ARRAY_DEPTH + 1,
  localparam int CMAW = $clog2(CMD)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]    position,
  input  logic [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]    left_end,
  input  logic [POS_W-1:0]    right_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FREQ_W-1:0]   max_frequency,
  output logic                range_error,
  output logic                st_we,
  output logic [AW-1:0]       st_addr,
  output logic [VW-1:0]       st_wdata,
  input  logic [VW-1:0]       st_rdata,
  output logic                cm_we,
  output logic [CMAW-1:0]     cm_addr,
  output logic [CW-1:0]       cm_wdata,
  input  logic [CW-1:0]       cm_rdata
);

  localparam int XW    = (CW > FREQ_W) ? CW : FREQ_W;
  localparam bit WIDE_RANGE  = VALUE_RANGE >= (2 ** VALUE_W);
  localparam int SMALL_RANGE = WIDE_RANGE ? 2 : VALUE_RANGE;
  localparam int RSHIFT      = VALUE_W + $clog2(SMALL_RANGE);
  localparam int RECIP       = ((2 ** RSHIFT) + SMALL_RANGE - 1) / SMALL_RANGE;
  localparam int PW          = 2 * VALUE_W + 2;

  typedef enum logic [14:0] {
    S_INIT = 15'h0001,
    S_IDLE = 15'h0002,
    S_MOD  = 15'h0004,
    S_LCHK = 15'h0008,
    S_LWR  = 15'h0010,
    S_QSTP = 15'h0020,
    S_CSTP = 15'h0040,
    S_SGOT = 15'h0080,
    S_BRD  = 15'h0100,
    S_BCNT = 15'h0200,
    S_BDEC = 15'h0400,
    S_BRDN = 15'h0800,
    S_BINC = 15'h1000,
    S_BWR  = 15'h2000,
    S_RES  = 15'h4000
  } state_t;

  typedef enum logic [1:0] {
    PH_QUERY, PH_CLEAR, PH_LOAD_OLD, PH_LOAD_NEW
  } phase_t;

  typedef enum logic [2:0] {
    MV_ADD_LO, MV_ADD_HI, MV_DEL_LO, MV_DEL_HI, MV_NONE
  } move_t;

  state_t           state;
  phase_t           phase;
  logic [CW-1:0]    loaded_len;
  logic [CW-1:0]    wlo;
  logic [CW-1:0]    whi;
  logic [CW-1:0]    cur_max;
  logic [CW-1:0]    q_lo;
  logic [CW-1:0]    q_hi;
  logic [VW-1:0]    elem_val;
  logic             up;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    ncnt;
  logic [VALUE_W-1:0] vsh;
  logic [VW-1:0]    rem;
  logic [POS_W-1:0] pos;
  logic [CMAW-1:0]  init_addr;
  logic             res_err;

  move_t            move;
  logic [CW-1:0]    q_pos;
  logic             skip;
  logic             bump_ret;
  logic [PW-1:0]    quo_prod;
  logic [VALUE_W-1:0] quo;
  logic [PW-1:0]    rem_full;
  logic [VW-1:0]    rem_calc;
  logic             bad_query;
  logic             in_window;

  assign in_ready = (state == S_IDLE);

  // Window move for a query, in the order of stretch low, stretch high,
  // shrink low, shrink high.
  always_comb begin
    move  = MV_NONE;
    q_pos = wlo;
    if (q_lo < wlo) begin
      move  = MV_ADD_LO;
      q_pos = wlo - CW'(1);
    end else if (whi < q_hi) begin
      move  = MV_ADD_HI;
      q_pos = whi;
    end else if (q_lo > wlo) begin
      move  = MV_DEL_LO;
      q_pos = wlo;
    end else if (whi > q_hi) begin
      move  = MV_DEL_HI;
      q_pos = whi - CW'(1);
    end
  end

  // The quotient by the value range comes from a multiplication by a rounded-up
  // reciprocal, which is exact for every value of the input width.
  assign quo_prod = PW'(vsh) * PW'(RECIP);
  assign quo      = VALUE_W'(quo_prod >> RSHIFT);
  assign rem_full = PW'(vsh) - PW'(quo) * PW'(SMALL_RANGE);
  assign rem_calc = WIDE_RANGE ? VW'(vsh) : VW'(rem_full);

  assign skip = up ? (cm_rdata >= CW'(ARRAY_DEPTH))
                   : ((cm_rdata == '0) || (cm_rdata > CW'(ARRAY_DEPTH)));
  assign bump_ret = (state == S_BWR) || ((state == S_BCNT) && skip);
  assign bad_query = (left_end > right_end) || (XW'(right_end) >= XW'(loaded_len));
  assign in_window = (XW'(pos) >= XW'(wlo)) && (XW'(pos) < XW'(whi));

  always_comb begin
    st_we    = 1'b0;
    st_addr  = '0;
    st_wdata = rem;
    cm_we    = 1'b0;
    cm_addr  = '0;
    cm_wdata = '0;
    unique case (state)
      S_INIT: begin
        cm_we   = 1'b1;
        cm_addr = init_addr;
      end
      S_QSTP: st_addr = AW'(q_pos);
      S_CSTP: st_addr = AW'(whi - CW'(1));
      S_LCHK: st_addr = AW'(pos);
      S_LWR: begin
        st_we   = 1'b1;
        st_addr = AW'(pos);
      end
      S_BRD:  cm_addr = CMAW'(elem_val);
      S_BCNT: cm_addr = CMAW'(VALUE_RANGE) + CMAW'(cm_rdata);
      S_BDEC: begin
        cm_we    = 1'b1;
        cm_addr  = CMAW'(VALUE_RANGE) + CMAW'(cnt);
        cm_wdata = cm_rdata - CW'(1);
      end
      S_BRDN: cm_addr = CMAW'(VALUE_RANGE) + CMAW'(ncnt);
      S_BINC: begin
        cm_we    = 1'b1;
        cm_addr  = CMAW'(VALUE_RANGE) + CMAW'(ncnt);
        cm_wdata = cm_rdata + CW'(1);
      end
      S_BWR: begin
        cm_we    = 1'b1;
        cm_addr  = CMAW'(elem_val);
        cm_wdata = ncnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_addr  <= '0;
      out_valid  <= 1'b0;
      loaded_len <= '0;
      wlo        <= '0;
      whi        <= '0;
      cur_max    <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_RES)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_addr <= init_addr + CMAW'(1);
          if (init_addr == CMAW'(CMD - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            unique case (action)
              ACT_CLEAR: begin
                phase <= PH_CLEAR;
                state <= S_CSTP;
              end
              ACT_LOAD: begin
                pos   <= position;
                vsh   <= value;
                state <= S_MOD;
              end
              ACT_QUERY: begin
                if (bad_query) begin
                  res_err <= 1'b1;
                  state   <= S_RES;
                end else begin
                  q_lo  <= CW'(left_end);
                  q_hi  <= CW'({1'b0, right_end} + 11'd1);
                  phase <= PH_QUERY;
                  state <= S_QSTP;
                end
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          rem   <= rem_calc;
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (XW'(pos) >= XW'(ARRAY_DEPTH)) begin
            state <= S_IDLE;
          end else if (in_window) begin
            phase <= PH_LOAD_OLD;
            up    <= 1'b0;
            state <= S_SGOT;
          end else begin
            state <= S_LWR;
          end
        end
        S_LWR: begin
          if (XW'(pos) + XW'(1) > XW'(loaded_len)) begin
            loaded_len <= CW'(XW'(pos) + XW'(1));
          end
          state <= S_IDLE;
        end
        S_QSTP: begin
          unique case (move)
            MV_ADD_LO: begin
              wlo   <= wlo - CW'(1);
              up    <= 1'b1;
              state <= S_SGOT;
            end
            MV_ADD_HI: begin
              whi   <= whi + CW'(1);
              up    <= 1'b1;
              state <= S_SGOT;
            end
            MV_DEL_LO: begin
              wlo   <= wlo + CW'(1);
              up    <= 1'b0;
              state <= S_SGOT;
            end
            MV_DEL_HI: begin
              whi   <= whi - CW'(1);
              up    <= 1'b0;
              state <= S_SGOT;
            end
            default: begin
              res_err <= 1'b0;
              state   <= S_RES;
            end
          endcase
        end
        S_CSTP: begin
          // Clearing removes the window one element at a time, which brings
          // every count back to zero.
          if (whi != wlo) begin
            whi   <= whi - CW'(1);
            up    <= 1'b0;
            state <= S_SGOT;
          end else begin
            wlo        <= '0;
            whi        <= '0;
            loaded_len <= '0;
            cur_max    <= '0;
            state      <= S_IDLE;
          end
        end
        S_SGOT: begin
          elem_val <= st_rdata;
          state    <= S_BRD;
        end
        S_BRD: state <= S_BCNT;
        S_BCNT: begin
          if (!skip) begin
            cnt  <= cm_rdata;
            ncnt <= up ? cm_rdata + CW'(1) : cm_rdata - CW'(1);
            if (up && (cm_rdata == '0)) begin
              state <= S_BRDN;
            end else begin
              state <= S_BDEC;
            end
          end
        end
        S_BDEC: begin
          if (!up && (cnt == cur_max) && (cm_rdata == CW'(1))) begin
            cur_max <= cnt - CW'(1);
          end
          state <= (ncnt != '0) ? S_BRDN : S_BWR;
        end
        S_BRDN: state <= S_BINC;
        S_BINC: state <= S_BWR;
        S_BWR: begin
          if (up && (ncnt > cur_max)) begin
            cur_max <= ncnt;
          end
        end
        S_RES: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            range_error   <= res_err;
            max_frequency <= res_err ? '0 : FREQ_W'(cur_max);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (bump_ret) begin
        unique case (phase)
          PH_QUERY: state <= S_QSTP;
          PH_CLEAR: state <= S_CSTP;
          PH_LOAD_OLD: begin
            elem_val <= rem;
            up       <= 1'b1;
            phase    <= PH_LOAD_NEW;
            state    <= S_BRD;
          end
          PH_LOAD_NEW: state <= S_LWR;
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

@@ dv/tb_sliding_window_mode_frequency.sv @@
// Self-checking testbench for sliding_window_mode_frequency: directed and random items
// with an in-bench predictor of the window counts. Depends on swm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_sliding_window_mode_frequency;
  import swm_pkg::*;

  localparam int DEPTH = DEF_ARRAY_DEPTH;
  localparam int VRANGE = DEF_VALUE_RANGE;
  localparam int STALL_LIMIT = 100000;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } swm_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic err;
  } swm_answer_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0] position;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0] left_end;
  logic [POS_W-1:0] right_end;
  logic out_valid;
  logic out_ready;
  logic [FREQ_W-1:0] max_frequency;
  logic range_error;

  sliding_window_mode_frequency dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position), .value(value),
    .left_end(left_end), .right_end(right_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .max_frequency(max_frequency), .range_error(range_error)
  );

  // Predicted state of the block.
  int stored_val[DEPTH];
  int val_count[VRANGE];
  int count_hist[DEPTH+1];
  int win_lo, win_hi, top_count, load_len;
  swm_answer_t pending_answers[$];
  int errors = 0;

  // Stimulus-side bookkeeping: positions 0..filled_len-1 have all been written,
  // so valid queries stay below min(load_len, filled_len).
  bit was_written[DEPTH];
  int filled_len = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void count_up(int v);
    int c;
    c = val_count[v];
    if (c >= DEPTH) return;
    if (c > 0) count_hist[c]--;
    c++;
    count_hist[c]++;
    val_count[v] = c;
    if (c > top_count) top_count = c;
  endfunction

  function automatic void count_down(int v);
    int c;
    c = val_count[v];
    if (c == 0) return;
    count_hist[c]--;
    if (c == top_count && count_hist[c] == 0) top_count = c - 1;
    c--;
    if (c > 0) count_hist[c]++;
    val_count[v] = c;
  endfunction

  function automatic void empty_window();
    foreach (val_count[i]) val_count[i] = 0;
    foreach (count_hist[i]) count_hist[i] = 0;
    top_count = 0;
    win_lo = 0;
    win_hi = 0;
  endfunction

  // Applies one accepted item to the predicted state and queues any answer.
  function automatic void track_mode_frequency(swm_item_t it);
    swm_answer_t ans;
    int l, r;
    l = it.lo;
    r = it.hi;
    case (it.act)
      ACT_CLEAR: begin
        empty_window();
        load_len = 0;
      end
      ACT_LOAD: begin
        if (it.pos >= win_lo && it.pos < win_hi) begin
          count_down(stored_val[it.pos]);
          count_up(it.val);
        end
        stored_val[it.pos] = it.val;
        if (it.pos + 1 > load_len) load_len = it.pos + 1;
      end
      ACT_QUERY: begin
        if (l > r || r >= load_len) begin
          ans.freq = '0;
          ans.err = 1'b1;
        end else begin
          while (l < win_lo) begin
            win_lo--;
            count_up(stored_val[win_lo]);
          end
          while (win_hi < r + 1) begin
            count_up(stored_val[win_hi]);
            win_hi++;
          end
          while (l > win_lo) begin
            count_down(stored_val[win_lo]);
            win_lo++;
          end
          while (win_hi > r + 1) begin
            win_hi--;
            count_down(stored_val[win_hi]);
          end
          ans.freq = top_count[FREQ_W-1:0];
          ans.err = 1'b0;
        end
        pending_answers = {pending_answers, ans};
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one item; the input valid is only lowered when a gap follows.
  task automatic send_item(swm_item_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.act;
    position <= it.pos;
    value <= it.val;
    left_end <= it.lo;
    right_end <= it.hi;
    do @(posedge clk); while (!in_ready);
    if (it.act == ACT_LOAD) begin
      was_written[it.pos] = 1'b1;
      while (filled_len < DEPTH && was_written[filled_len]) filled_len++;
    end
    track_mode_frequency(it);
  endtask

  function automatic swm_item_t make_item(logic [ACTION_W-1:0] a, int p, int v, int l, int r);
    swm_item_t it;
    it.act = a;
    it.pos = p[POS_W-1:0];
    it.val = v[VALUE_W-1:0];
    it.lo = l[POS_W-1:0];
    it.hi = r[POS_W-1:0];
    return it;
  endfunction

  task automatic test_empty_and_bad_bounds();
    send_item(make_item(ACT_CLEAR, 1023, 1023, 1023, 1023));
    send_item(make_item(ACT_QUERY, 0, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 1023, 1023, 1023, 1023));
    send_item(make_item(ACT_LOAD, 0, 0, 0, 0));
    send_item(make_item(ACT_LOAD, 1, 1023, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 1023, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 0, 2));
    send_item(make_item(ACT_NONE, 5, 7, 0, 1));
  endtask

  task automatic test_window_moves();
    send_item(make_item(ACT_LOAD, 2, 0, 0, 0));
    send_item(make_item(ACT_LOAD, 3, 0, 0, 0), 1);
    send_item(make_item(ACT_QUERY, 0, 0, 0, 3), 1);
    send_item(make_item(ACT_QUERY, 0, 0, 1, 1));
    send_item(make_item(ACT_QUERY, 0, 0, 0, 3));
    // Loads that land inside the current window rewrite the counts.
    send_item(make_item(ACT_LOAD, 1, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 0, 3));
    send_item(make_item(ACT_LOAD, 0, 1023, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 2, 3));
    send_item(make_item(ACT_LOAD, 1023, 5, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 1, 3));
    send_item(make_item(ACT_QUERY, 0, 0, 3, 3));
    send_item(make_item(ACT_CLEAR, 0, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 0, 0, 0));
  endtask

  task automatic test_random_mix(int n);
    swm_item_t it;
    int p, lim, l, r, vmax;
    for (int k = 0; k < n; k++) begin
      it.pos = $urandom;
      it.val = $urandom;
      it.lo = $urandom;
      it.hi = $urandom;
      lim = (load_len < filled_len) ? load_len : filled_len;
      p = $urandom_range(99);
      if (p < 3) begin
        it.act = ACT_CLEAR;
      end else if (p < 6) begin
        it.act = ACT_NONE;
      end else if (p < 52) begin
        it.act = ACT_LOAD;
        p = $urandom_range(99);
        if (p < 60 && filled_len < DEPTH) it.pos = filled_len;
        else if (p < 92 && filled_len > 0) it.pos = $urandom_range(filled_len - 1);
        vmax = ($urandom_range(9) == 0) ? 1023 : 7;
        it.val = $urandom_range(vmax);
      end else begin
        it.act = ACT_QUERY;
        p = $urandom_range(99);
        if (lim > 0 && p < 80) begin
          // Mostly short moves around the current window to bound the cost.
          r = (win_hi > 0 ? win_hi - 1 : 0) + $urandom_range(32) - 16;
          if (r < 0) r = 0;
          if (r > lim - 1) r = lim - 1;
          l = win_lo + $urandom_range(32) - 16;
          if (l < 0) l = 0;
          if (l > r) l = r;
          it.lo = l;
          it.hi = r;
        end else if (lim > 0 && p < 84) begin
          it.lo = 0;
          it.hi = lim - 1;
        end else if (p < 92 && load_len < DEPTH) begin
          it.hi = $urandom_range(DEPTH - 1, load_len);
        end else begin
          r = $urandom_range(DEPTH - 2);
          it.hi = r;
          it.lo = $urandom_range(DEPTH - 1, r + 1);
        end
      end
      send_item(it);
    end
  endtask

  // Result side: random back-pressure, with long stretches of none.
  initial begin
    int mode;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(9);
      repeat ($urandom_range(5, 60)) begin
        if (mode < 4) out_ready <= 1'b1;
        else if (mode < 9) out_ready <= ($urandom_range(2) != 0);
        else out_ready <= ($urandom_range(7) == 0);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    swm_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result with no query outstanding: max_frequency %0d range_error %0d",
               max_frequency, range_error);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (max_frequency !== want.freq) begin
          $error("max_frequency expected %0d actual %0d", want.freq, max_frequency);
          errors++;
        end
        if (range_error !== want.err) begin
          $error("range_error expected %0d actual %0d", want.err, range_error);
          errors++;
        end
      end
    end
  end

  // Ends the run when nothing moves on either side for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_CLEAR;
    position = '0;
    value = '0;
    left_end = '0;
    right_end = '0;
    foreach (stored_val[i]) stored_val[i] = 0;
    load_len = 0;
    empty_window();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_bad_bounds();
    test_window_moves();
    test_random_mix(1180);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
